// ----- rtl/plane_from_points_distance_core_assert.svh -----
// Assertion helpers for the plane distance core
`ifndef PLANE_FROM_POINTS_DISTANCE_CORE_ASSERT_SVH
`define PLANE_FROM_POINTS_DISTANCE_CORE_ASSERT_SVH

`define PFPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfpd assertion failed");

`define PFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfpd assertion failed");

`endif

// ----- rtl/pfpd_pkg.sv -----
package pfpd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_POINT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_POINT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THIRD_POINT  = 2'd2;

	localparam int UNIT_W = 32;
	localparam int DIST_W = 32;

	typedef struct packed {
		logic busy;
		logic degenerate;
	} pfpd_status_t;

endpackage

// ----- rtl/pfpd_setup.sv -----
module pfpd_setup #(
	parameter int COORD_WIDTH = pfpd_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [3*COORD_WIDTH-1:0]           cfg_data,
	output logic [3*COORD_WIDTH-1:0]           first_point,
	output logic signed [pfpd_pkg::UNIT_W-1:0] unit_x,
	output logic signed [pfpd_pkg::UNIT_W-1:0] unit_y,
	output logic signed [pfpd_pkg::UNIT_W-1:0] unit_z,
	output pfpd_pkg::pfpd_status_t             status
);

	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;
	localparam int PRW = 2 * DW;
	localparam int NW  = PRW + 1;
	localparam int SHW = ((NW > 31) ? NW : 31) + 1;
	localparam int UW  = pfpd_pkg::UNIT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_CROSS, S_SHIFT, S_SQUARE, S_ROOT, S_DIV_LOAD, S_DIV_RUN
	} state_t;

	state_t state_q;
	logic [3*W-1:0] pt_q [3];
	logic signed [UW-1:0] u_q [3];
	logic degenerate_q;
	logic [4:0] cnt_q;
	logic [1:0] lane_q;
	logic signed [PRW-1:0] prod_q;
	logic [SHW-1:0] mag_q [3];
	logic sgn_q [3];
	logic [63:0] sum_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [31:0] drem_q;
	logic [30:0] dnum_q;
	logic [30:0] quo_q;

	logic signed [DW-1:0] v1 [3];
	logic signed [DW-1:0] v2 [3];
	logic signed [DW-1:0] op_a, op_b;
	logic signed [PRW-1:0] prod;
	logic signed [NW-1:0] nval;
	logic [SHW-1:0] nmag;
	logic [SHW-1:0] big;
	logic [61:0] sq;
	logic [63:0] rt_t;
	logic [31:0] root;
	logic [61:0] num;
	logic [32:0] dv_t;
	logic dv_ge;
	logic [30:0] quo_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v1[i] = DW'($signed(pt_q[0][i*W +: W])) - DW'($signed(pt_q[1][i*W +: W]));
			v2[i] = DW'($signed(pt_q[0][i*W +: W])) - DW'($signed(pt_q[2][i*W +: W]));
		end
		case (cnt_q[2:0])
			3'd0: begin op_a = v1[1]; op_b = v2[2]; end
			3'd1: begin op_a = v2[1]; op_b = v1[2]; end
			3'd2: begin op_a = v2[0]; op_b = v1[2]; end
			3'd3: begin op_a = v1[0]; op_b = v2[2]; end
			3'd4: begin op_a = v1[0]; op_b = v2[1]; end
			3'd5: begin op_a = v2[0]; op_b = v1[1]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		prod = PRW'(op_a) * PRW'(op_b);
		nval = NW'(prod_q) - NW'(prod);
		nmag = nval[NW-1] ? SHW'(-nval) : SHW'(nval);
		big = mag_q[0];
		if (mag_q[1] > big) big = mag_q[1];
		if (mag_q[2] > big) big = mag_q[2];
		sq = 62'(mag_q[cnt_q[1:0]][30:0]) * 62'(mag_q[cnt_q[1:0]][30:0]);
		rt_t = res_q + bit_q;
		root = res_q[31:0];
		num = {mag_q[lane_q][30:0], 30'd0} + 62'(root[31:1]);
		dv_t = {drem_q, dnum_q[30]};
		dv_ge = dv_t >= {1'b0, root};
		quo_n = {quo_q[29:0], dv_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			degenerate_q <= 1'b1;
			cnt_q <= '0;
			lane_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pt_q[i] <= '0;
				u_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index == pfpd_pkg::REG_FIRST_POINT ||
				cfg_index == pfpd_pkg::REG_SECOND_POINT ||
				cfg_index == pfpd_pkg::REG_THIRD_POINT)) begin
			pt_q[cfg_index] <= cfg_data;
			degenerate_q <= 1'b0;
			cnt_q <= '0;
			state_q <= S_CROSS;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
				end
				S_CROSS: begin
					if (!cnt_q[0]) begin
						prod_q <= prod;
					end else begin
						mag_q[cnt_q[2:1]] <= nmag;
						sgn_q[cnt_q[2:1]] <= nval[NW-1];
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd5) state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (big == '0) begin
						degenerate_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (big[SHW-1:31] != '0) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (!big[30]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						cnt_q <= '0;
						sum_q <= '0;
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					sum_q <= sum_q + 64'(sq);
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						res_q <= '0;
						bit_q <= 64'd1 << 62;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (bit_q == '0) begin
						lane_q <= '0;
						state_q <= S_DIV_LOAD;
					end else begin
						if (sum_q >= rt_t) begin
							sum_q <= sum_q - rt_t;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_DIV_LOAD: begin
					drem_q <= {1'b0, num[61:31]};
					dnum_q <= num[30:0];
					quo_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					drem_q <= dv_ge ? 32'(dv_t - {1'b0, root}) : dv_t[31:0];
					dnum_q <= dnum_q << 1;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						u_q[lane_q] <= sgn_q[lane_q] ? -$signed(UW'(quo_n)) : $signed(UW'(quo_n));
						if (lane_q == 2'd2) begin
							state_q <= S_IDLE;
						end else begin
							lane_q <= lane_q + 2'd1;
							state_q <= S_DIV_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign first_point = pt_q[0];
	assign unit_x = u_q[0];
	assign unit_y = u_q[1];
	assign unit_z = u_q[2];
	assign status.busy = (state_q != S_IDLE);
	assign status.degenerate = degenerate_q;

endmodule

// ----- rtl/pfpd_dot.sv -----
module pfpd_dot #(
	parameter int COORD_WIDTH = pfpd_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = pfpd_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 take,
	input  logic signed [COORD_WIDTH-1:0]        qx,
	input  logic signed [COORD_WIDTH-1:0]        qy,
	input  logic signed [COORD_WIDTH-1:0]        qz,
	input  logic [3*COORD_WIDTH-1:0]             p1,
	input  logic signed [pfpd_pkg::UNIT_W-1:0]   ux,
	input  logic signed [pfpd_pkg::UNIT_W-1:0]   uy,
	input  logic signed [pfpd_pkg::UNIT_W-1:0]   uz,
	input  logic                                 degen,
	output logic                                 valid_s4,
	output logic signed [pfpd_pkg::DIST_W-1:0]   dist_s4,
	output logic                                 degen_s4
);

	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;
	localparam int UW  = pfpd_pkg::UNIT_W;
	localparam int PW  = UW + DW;
	localparam int AW  = PW + 2;
	localparam int K   = 14 + FRAC_BITS;
	localparam logic signed [AW:0] SAT_MAX = $signed({{(AW-30){1'b0}}, {31{1'b1}}});
	localparam logic signed [AW:0] SAT_MIN = $signed({{(AW-30){1'b1}}, {31{1'b0}}});
	localparam logic signed [AW:0] RND     = $signed({{AW{1'b0}}, 1'b1}) <<< (K - 1);

	logic valid_s1, valid_s2, valid_s3;
	logic signed [DW-1:0] diff_s1 [3];
	logic signed [PW-1:0] prod_s2 [3];
	logic signed [AW-1:0] acc_s3;
	logic signed [UW-1:0] u [3];
	logic signed [W-1:0] q [3];
	logic signed [AW:0] rnd;

	always_comb begin
		u[0] = ux; u[1] = uy; u[2] = uz;
		q[0] = qx; q[1] = qy; q[2] = qz;
		rnd = ((AW+1)'(acc_s3) + RND) >>> K;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= DW'(q[i]) - DW'($signed(p1[i*W +: W]));
				prod_s2[i] <= PW'(u[i]) * PW'(diff_s1[i]);
			end
			acc_s3 <= AW'(prod_s2[0]) + AW'(prod_s2[1]) + AW'(prod_s2[2]);
			degen_s4 <= degen;
			if (degen) begin
				dist_s4 <= '0;
			end else if (rnd > SAT_MAX) begin
				dist_s4 <= SAT_MAX[pfpd_pkg::DIST_W-1:0];
			end else if (rnd < SAT_MIN) begin
				dist_s4 <= SAT_MIN[pfpd_pkg::DIST_W-1:0];
			end else begin
				dist_s4 <= rnd[pfpd_pkg::DIST_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/plane_from_points_distance_core.sv -----
// Signed distance of query points from the plane through three points.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0,
// 1 and 2 write the first, second and third point (x low, z high); cfg_ready
// is always high. Each write restarts the plane setup sequencer, which rebuilds
// the unit normal with one shared multiplier for the cross product, a squarer,
// a bit-pair square root and a restoring divider. On collinear points it flags
// the plane degenerate after the cross product; otherwise it goes on to the
// normalising shift, the squares, the root and the three divisions. in_ready
// stays low while it runs. Write points only while no transaction is in flight.
// Input channel (in_valid/in_ready, query_x/y/z): one transaction per cycle
// while in_ready is high. Output channel (out_valid/out_ready, signed_distance,
// degenerate): four register stages, the first loaded at the accepting edge and
// out_valid taken from the last; throughput is one transaction per cycle while
// the setup is idle and the receiver keeps up. A stalled receiver holds the
// whole pipeline in place and drops in_ready; nothing is lost or repeated.
// Reset clears the points to zero, which reads as a degenerate plane, and
// empties the pipeline.
module plane_from_points_distance_core #(
	parameter int COORD_WIDTH = pfpd_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = pfpd_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [3*COORD_WIDTH-1:0]            cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       query_x,
	input  logic signed [COORD_WIDTH-1:0]       query_y,
	input  logic signed [COORD_WIDTH-1:0]       query_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pfpd_pkg::DIST_W-1:0]  signed_distance,
	output logic                                degenerate
);

	`include "plane_from_points_distance_core_assert.svh"

	logic [3*COORD_WIDTH-1:0] first_point;
	logic signed [pfpd_pkg::UNIT_W-1:0] unit_x, unit_y, unit_z;
	pfpd_pkg::pfpd_status_t status;
	logic en;
	logic cfg_write;

	assign en = !out_valid || out_ready;
	assign in_ready = en && !status.busy;
	assign cfg_write = cfg_valid && cfg_ready &&
		(cfg_index == pfpd_pkg::REG_FIRST_POINT ||
		cfg_index == pfpd_pkg::REG_SECOND_POINT ||
		cfg_index == pfpd_pkg::REG_THIRD_POINT);

	pfpd_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.first_point(first_point),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.status(status)
	);

	pfpd_dot #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot (
		.clk(clk), .arst_n(arst_n), .en(en),
		.take(in_valid && in_ready),
		.qx(query_x), .qy(query_y), .qz(query_z),
		.p1(first_point),
		.ux(unit_x), .uy(unit_y), .uz(unit_z),
		.degen(status.degenerate),
		.valid_s4(out_valid), .dist_s4(signed_distance), .degen_s4(degenerate)
	);

	`PFPD_ASSERT_SAME(a_no_take_busy, clk, arst_n, in_valid && in_ready, !status.busy)
	`PFPD_ASSERT_SAME(a_degen_zero, clk, arst_n, out_valid && degenerate, signed_distance == '0)
	`PFPD_ASSERT_NEXT(a_cfg_starts, clk, arst_n, cfg_write, status.busy && !in_ready)

endmodule

// ----- sim/tb_plane_from_points_distance_core.sv -----
module tb_plane_from_points_distance_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = pfpd_pkg::COORD_WIDTH_DEF;
	localparam int FB = pfpd_pkg::FRAC_BITS_DEF;
	localparam int DIST_W = pfpd_pkg::DIST_W;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [DIST_W-1:0] distance;
		logic degen;
	} distance_t;

	class plane_scoreboard;
		logic [3*CW-1:0] points[3];
		distance_t expected_q[$];
		int mismatches;

		function new();
			foreach (points[i]) points[i] = '0;
			mismatches = 0;
		endfunction

		function void set_point(int idx, logic [3*CW-1:0] value);
			points[idx] = value;
		endfunction

		function longint coord_of(int pt, int axis);
			logic signed [CW-1:0] c;
			c = points[pt][axis*CW +: CW];
			return longint'(c);
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void note_query(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
				logic signed [CW-1:0] qz);
			longint p1[3], v1[3], v2[3], nrm[3], unit[3], q[3];
			longint unsigned mag[3], big, sum, root, quot;
			longint acc, d;
			int rsh, lsh;
			distance_t e;
			q[0] = longint'(qx);
			q[1] = longint'(qy);
			q[2] = longint'(qz);
			for (int i = 0; i < 3; i++) begin
				p1[i] = coord_of(0, i);
				v1[i] = p1[i] - coord_of(1, i);
				v2[i] = p1[i] - coord_of(2, i);
			end
			nrm[0] = v1[1] * v2[2] - v2[1] * v1[2];
			nrm[1] = v2[0] * v1[2] - v1[0] * v2[2];
			nrm[2] = v1[0] * v2[1] - v2[0] * v1[1];
			big = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = (nrm[i] < 0) ? longint'(-nrm[i]) : longint'(nrm[i]);
				if (mag[i] > big) big = mag[i];
			end
			if (big == 0) begin
				e.distance = '0;
				e.degen = 1'b1;
				expected_q.push_back(e);
				return;
			end
			rsh = 0;
			lsh = 0;
			while ((big >> rsh) >= (64'd1 << 31)) rsh++;
			while ((big << lsh) < (64'd1 << 30)) lsh++;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = (mag[i] >> rsh) << lsh;
				sum = sum + mag[i] * mag[i];
			end
			root = int_sqrt(sum);
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				quot = ((mag[i] << 30) + (root >> 1)) / root;
				unit[i] = (nrm[i] < 0) ? -longint'(quot) : longint'(quot);
				acc = acc + unit[i] * (q[i] - p1[i]);
			end
			d = (acc + (64'sd1 <<< (13 + FB))) >>> (14 + FB);
			if (d > 64'sd2147483647) d = 64'sd2147483647;
			if (d < -64'sd2147483648) d = -64'sd2147483648;
			e.distance = d[DIST_W-1:0];
			e.degen = 1'b0;
			expected_q.push_back(e);
		endfunction

		function void check_result(logic signed [DIST_W-1:0] distance, logic degen);
			distance_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: dist=%0d degenerate=%0b", distance, degen);
				return;
			end
			e = expected_q.pop_front();
			if (distance !== e.distance || degen !== e.degen) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %0d/%0b, got %0d/%0b",
						e.distance, e.degen, distance, degen);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pfpd_pkg::CFG_IDX_W-1:0] cfg_index = pfpd_pkg::REG_FIRST_POINT;
	logic [3*CW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] query_x = '0;
	logic signed [CW-1:0] query_y = '0;
	logic signed [CW-1:0] query_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DIST_W-1:0] signed_distance;
	logic degenerate;

	plane_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	plane_from_points_distance_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.query_x(query_x),
		.query_y(query_y),
		.query_z(query_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.signed_distance(signed_distance),
		.degenerate(degenerate)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(signed_distance, degenerate);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [3*CW-1:0] pack_point(int x, int y, int z);
		logic [CW-1:0] px, py, pz;
		px = x[CW-1:0];
		py = y[CW-1:0];
		pz = z[CW-1:0];
		return {pz, py, px};
	endfunction

	task automatic drain_results();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_point(logic [pfpd_pkg::CFG_IDX_W-1:0] idx, logic [3*CW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_point(int'(idx), value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_plane(logic [3*CW-1:0] a, logic [3*CW-1:0] b, logic [3*CW-1:0] c);
		drain_results();
		write_point(pfpd_pkg::REG_FIRST_POINT, a);
		write_point(pfpd_pkg::REG_SECOND_POINT, b);
		write_point(pfpd_pkg::REG_THIRD_POINT, c);
	endtask

	task automatic send_query(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		in_valid <= 1'b1;
		query_x <= x;
		query_y <= y;
		query_z <= z;
		do @(posedge clk); while (!in_ready);
		sb.note_query(x, y, z);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_query(CW'($urandom), CW'($urandom), CW'($urandom));
	endtask

	function automatic logic [3*CW-1:0] random_point();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[3*CW-1:0];
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset leaves a degenerate plane
		send_query(16'h7fff, 16'h8000, 16'h0000);
		send_query(16'h8000, 16'h7fff, 16'hffff);
		send_query(16'h0000, 16'h0000, 16'h0000);
		in_valid <= 1'b0;

		set_plane(pack_point(0, 0, 0), pack_point(256, 0, 0), pack_point(0, 256, 0));
		send_query(16'h0000, 16'h0000, 16'h0100);
		send_query(16'h7fff, 16'h7fff, 16'h7fff);
		send_query(16'h8000, 16'h8000, 16'h8000);
		send_query(16'h0000, 16'h0000, 16'h8000);
		send_query(16'h1234, 16'h4321, 16'hff00);
		in_valid <= 1'b0;

		// widest spread: cross product needs a right shift
		set_plane(pack_point(-32768, -32768, -32768), pack_point(32767, -32768, 32767),
			pack_point(-32768, 32767, 32767));
		send_query(16'h7fff, 16'h7fff, 16'h7fff);
		send_query(16'h8000, 16'h8000, 16'h8000);
		send_query(16'h7fff, 16'h8000, 16'h7fff);
		in_valid <= 1'b0;

		// one-lsb spread: cross product needs a left shift
		set_plane(pack_point(5, -7, 3), pack_point(6, -7, 3), pack_point(5, -6, 4));
		send_query(16'h7fff, 16'h8000, 16'h7fff);
		send_query(16'h8000, 16'h7fff, 16'h8000);
		in_valid <= 1'b0;

		// collinear but distinct points
		set_plane(pack_point(100, 200, -300), pack_point(200, 400, -600),
			pack_point(-100, -200, 300));
		send_query(16'h0100, 16'h0200, 16'h0300);
		send_query(16'h7fff, 16'h7fff, 16'h7fff);
		in_valid <= 1'b0;

		for (int phase = 0; phase < 9; phase++) begin
			set_plane(random_point(), random_point(), random_point());
			if (phase < 3) begin
				send_idle = 14;
				recv_idle = 87;
			end else if (phase < 6) begin
				send_idle = 87;
				recv_idle = 14;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (phase == 6) hold_cycles = 300;
			send_random(100);
			in_valid <= 1'b0;
		end

		drain_results();
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
